>>> design/dre_pkg.sv
// Package for the decimal to Roman numeral encoder.
// Holds widths, ASCII symbol codes, the greedy symbol table and the
// controller/datapath interface structs. No dependencies.
package dre_pkg;

  localparam int ValueW     = 12;
  localparam int CharW      = 7;
  localparam int InDataW    = 16;
  localparam int OutDataW   = 8;
  localparam int EntryValW  = 10;
  localparam int NumEntries = 13;

  localparam logic [ValueW-1:0] ValueLimit = 12'd4000;

  localparam logic [CharW-1:0] ChM = 7'h4D;
  localparam logic [CharW-1:0] ChD = 7'h44;
  localparam logic [CharW-1:0] ChC = 7'h43;
  localparam logic [CharW-1:0] ChL = 7'h4C;
  localparam logic [CharW-1:0] ChX = 7'h58;
  localparam logic [CharW-1:0] ChV = 7'h56;
  localparam logic [CharW-1:0] ChI = 7'h49;
  localparam logic [CharW-1:0] ChNone = 7'h00;

  // Greedy table, largest value first
  localparam logic [EntryValW-1:0] EntryVal [NumEntries] = '{
    10'd1000, 10'd900, 10'd500, 10'd400, 10'd100, 10'd90, 10'd50,
    10'd40, 10'd10, 10'd9, 10'd5, 10'd4, 10'd1
  };
  localparam logic [CharW-1:0] EntryCh1 [NumEntries] = '{
    ChM, ChC, ChD, ChC, ChC, ChX, ChL, ChX, ChX, ChI, ChV, ChI, ChI
  };
  localparam logic [CharW-1:0] EntryCh2 [NumEntries] = '{
    ChNone, ChM, ChNone, ChD, ChNone, ChC, ChNone, ChL, ChNone, ChX, ChNone,
    ChV, ChNone
  };
  localparam logic EntryPair [NumEntries] = '{
    1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
    1'b1, 1'b0
  };

  typedef struct packed {
    logic [EntryValW-1:0] val;
    logic [CharW-1:0]     ch1;
    logic [CharW-1:0]     ch2;
    logic                 pair;
  } entry_t;

  typedef struct packed {
    logic load;
    logic step;
  } dre_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last;
  } dre_sts_t;

  // Largest table entry not above the remainder
  function automatic entry_t entry_lookup(input logic [ValueW-1:0] rem);
    entry_t ent;
    ent.val  = EntryVal[NumEntries-1];
    ent.ch1  = EntryCh1[NumEntries-1];
    ent.ch2  = EntryCh2[NumEntries-1];
    ent.pair = EntryPair[NumEntries-1];
    for (int i = NumEntries - 1; i >= 0; i--) begin
      if (rem >= {{(ValueW-EntryValW){1'b0}}, EntryVal[i]}) begin
        ent.val  = EntryVal[i];
        ent.ch1  = EntryCh1[i];
        ent.ch2  = EntryCh2[i];
        ent.pair = EntryPair[i];
      end
    end
    return ent;
  endfunction

endpackage

>>> design/dre_ctrl.sv
// Controller state machine of the Roman numeral encoder.
// Sequences load and character steps; depends on dre_pkg.
module dre_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dre_pkg::dre_sts_t sts_i,
  output dre_pkg::dre_cmd_t cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic state_q, state_d;
  logic step;

  assign step       = (state_q == StRun) && sts_i.out_free;
  assign in_ready_o = (state_q == StIdle) || (step && sts_i.last);
  assign cmd_o.step = step;
  assign cmd_o.load = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    priority if (cmd_o.load) begin
      state_d = StRun;
    end else if (step && sts_i.last) begin
      state_d = StIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/dre_datapath.sv
// Datapath of the Roman numeral encoder: remainder, greedy symbol pick and
// output register. Depends on dre_pkg.
module dre_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [dre_pkg::ValueW-1:0]  value_i,
  input  dre_pkg::dre_cmd_t           cmd_i,
  output dre_pkg::dre_sts_t           sts_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [dre_pkg::CharW-1:0]   out_char_o,
  output logic                        out_last_o,
  output logic                        out_invalid_o
);

  logic [dre_pkg::ValueW-1:0] rem_q, rem_d;
  logic                       invalid_q, invalid_d;
  logic                       second_q, second_d;
  logic                       out_valid_q, out_valid_d;
  logic [dre_pkg::CharW-1:0]  char_q, char_d;
  logic                       last_q, last_d;
  logic                       inv_out_q, inv_out_d;
  dre_pkg::entry_t            ent;
  logic                       done_entry;
  logic [dre_pkg::ValueW-1:0] ent_val;
  logic                       cur_last;
  logic [dre_pkg::CharW-1:0]  cur_char;

  assign ent        = dre_pkg::entry_lookup(rem_q);
  assign ent_val    = {{(dre_pkg::ValueW-dre_pkg::EntryValW){1'b0}}, ent.val};
  assign done_entry = !ent.pair || second_q;
  assign cur_last   = invalid_q || (done_entry && (rem_q == ent_val));
  assign cur_char   = invalid_q ? dre_pkg::ChNone : (second_q ? ent.ch2 : ent.ch1);

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.last     = cur_last;

  always_comb begin
    rem_d       = rem_q;
    invalid_d   = invalid_q;
    second_d    = second_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    inv_out_d   = inv_out_q;
    if (cmd_i.step) begin
      out_valid_d = 1'b1;
      char_d      = cur_char;
      last_d      = cur_last;
      inv_out_d   = invalid_q;
      second_d    = ent.pair && !second_q;
      if (done_entry) begin
        rem_d = rem_q - ent_val;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load) begin
      rem_d     = value_i;
      invalid_d = (value_i == '0) || (value_i >= dre_pkg::ValueLimit);
      second_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invalid_q   <= 1'b0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      invalid_q   <= invalid_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    char_q    <= char_d;
    last_q    <= last_d;
    inv_out_q <= inv_out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = char_q;
  assign out_last_o    = last_q;
  assign out_invalid_o = inv_out_q;

  a_step_has_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step && !invalid_q |-> rem_q != '0)
    else $error("character step with empty remainder");

  a_second_on_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> ent.pair)
    else $error("pending second character outside a subtractive pair");

  a_step_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> sts_o.out_free)
    else $error("step into an occupied output register");

  a_last_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step && cur_last |=> out_valid_q && last_q)
    else $error("final character not flagged");

endmodule

>>> design/decimal_to_roman_encoder_unit.sv
// Decimal to Roman numeral encoder, top level. Instantiates dre_ctrl and
// dre_datapath; depends on dre_pkg.
// The accepted input word is loaded into the remainder register; the greedy
// symbol step then emits one character per cycle into the output register
// while it is free (m_axis_tready not stalling it): a single character for an
// invalid number, up to 15 for 3888.
// Reset: asynchronous active low; clears the controller and output valid.
module decimal_to_roman_encoder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [dre_pkg::InDataW-1:0]   s_axis_tdata_i,  // [11:0] number_value
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [dre_pkg::OutDataW-1:0]  m_axis_tdata_o,  // [6:0] numeral_char
  output logic                          m_axis_tlast_o,  // last_char
  output logic                          m_axis_tuser_o   // [0] invalid_value
);

  dre_pkg::dre_cmd_t          cmd;
  dre_pkg::dre_sts_t          sts;
  logic [dre_pkg::CharW-1:0]  out_char;

  dre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dre_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (s_axis_tdata_i[dre_pkg::ValueW-1:0]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_char_o    (out_char),
    .out_last_o    (m_axis_tlast_o),
    .out_invalid_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {{(dre_pkg::OutDataW-dre_pkg::CharW){1'b0}}, out_char};

endmodule

>>> sim/tb_decimal_to_roman_encoder_unit.sv
// Testbench for decimal_to_roman_encoder_unit: streams numbers in and checks
// every numeral character against a digit-by-digit predictor in a scoreboard.
// Depends on dre_pkg and the encoder RTL.
`timescale 1ns / 100ps

module tb_decimal_to_roman_encoder_unit;

  localparam int          RandomWords = 255;
  localparam int          QuietWords  = 40;
  localparam int          PressureAt  = 100;
  localparam int          PressureLen = 20;
  localparam int          HoldCycles  = 300;
  localparam int          DrainCycles = 40;
  localparam int unsigned CycleLimit  = 500000;

  class numeral_tracker;
    typedef struct packed {
      logic [dre_pkg::CharW-1:0] glyph;
      logic                      last;
      logic                      bad;
    } glyph_t;

    glyph_t      pending_glyphs[$];
    int unsigned errors = 0;

    function void put_glyph(logic [dre_pkg::CharW-1:0] g);
      glyph_t e;
      e.glyph = g;
      e.last  = 1'b0;
      e.bad   = 1'b0;
      pending_glyphs.push_back(e);
    endfunction

    function void put_digit(int unsigned d, logic [dre_pkg::CharW-1:0] one,
                            logic [dre_pkg::CharW-1:0] five,
                            logic [dre_pkg::CharW-1:0] ten);
      if (d == 9) begin
        put_glyph(one);
        put_glyph(ten);
      end else if (d == 4) begin
        put_glyph(one);
        put_glyph(five);
      end else begin
        if (d >= 5) begin
          put_glyph(five);
          d = d - 5;
        end
        repeat (d) put_glyph(one);
      end
    endfunction

    function void note_number(logic [dre_pkg::ValueW-1:0] v);
      int unsigned n;
      glyph_t      e;
      n = 32'(v);
      if (n == 0 || v >= dre_pkg::ValueLimit) begin
        e.glyph = dre_pkg::ChNone;
        e.last  = 1'b1;
        e.bad   = 1'b1;
        pending_glyphs.push_back(e);
      end else begin
        repeat (n / 1000) put_glyph(dre_pkg::ChM);
        put_digit((n / 100) % 10, dre_pkg::ChC, dre_pkg::ChD, dre_pkg::ChM);
        put_digit((n / 10) % 10, dre_pkg::ChX, dre_pkg::ChL, dre_pkg::ChC);
        put_digit(n % 10, dre_pkg::ChI, dre_pkg::ChV, dre_pkg::ChX);
        // flag the final character of this number
        e = pending_glyphs.pop_back();
        e.last = 1'b1;
        pending_glyphs.push_back(e);
      end
    endfunction

    function void check_char(logic [dre_pkg::CharW-1:0] g, logic last, logic bad);
      glyph_t e;
      if (pending_glyphs.size() == 0) begin
        $error("numeral_char: no character expected, got %0h", g);
        errors++;
      end else begin
        e = pending_glyphs.pop_front();
        if (g !== e.glyph) begin
          $error("numeral_char: expected %0h, got %0h", e.glyph, g);
          errors++;
        end
        if (last !== e.last) begin
          $error("last_char: expected %0b, got %0b", e.last, last);
          errors++;
        end
        if (bad !== e.bad) begin
          $error("invalid_value: expected %0b, got %0b", e.bad, bad);
          errors++;
        end
      end
    endfunction

    function int outstanding();
      return pending_glyphs.size();
    endfunction
  endclass

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic [dre_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                         m_axis_tready = 1'b0;
  logic                         s_axis_tready;
  logic                         m_axis_tvalid;
  logic [dre_pkg::OutDataW-1:0] m_axis_tdata;
  logic                         m_axis_tlast;
  logic                         m_axis_tuser;

  bit hold_out = 1'b0;
  bit quiet    = 1'b0;

  numeral_tracker tracker;

  int unsigned corner_values[25] = '{
    0, 1, 3, 4, 5, 8, 9, 10, 14, 40, 49, 90, 99, 400, 444, 500, 900, 999, 1000,
    1994, 2730, 3888, 3999, 4000, 4095
  };

  decimal_to_roman_encoder_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        tracker.note_number(s_axis_tdata[dre_pkg::ValueW-1:0]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        tracker.check_char(m_axis_tdata[dre_pkg::CharW-1:0], m_axis_tlast, m_axis_tuser);
      end
    end
  end

  task automatic send_word(input logic [dre_pkg::ValueW-1:0] v);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(dre_pkg::InDataW-dre_pkg::ValueW){1'b0}}, v};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic idle_sender();
    if ($urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  function automatic logic [dre_pkg::ValueW-1:0] pick_number();
    int unsigned r;
    int unsigned v;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      v = $urandom_range(4000, 4095);
    end else if (r < 10) begin
      v = 0;
    end else if (r < 20) begin
      v = $urandom_range(3000, 3999);
    end else begin
      v = $urandom_range(1, 3999);
    end
    return v[dre_pkg::ValueW-1:0];
  endfunction

  // sink side: random stalls, one long hold-off, none at the end
  initial begin : sink
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (quiet) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else if (hold_out) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_out = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    tracker = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_values[i]) begin
      send_word(corner_values[i][dre_pkg::ValueW-1:0]);
      idle_sender();
    end

    for (int k = 0; k < RandomWords; k++) begin
      if (k == PressureAt) hold_out = 1'b1;
      if (k == RandomWords - QuietWords) quiet = 1'b1;
      send_word(pick_number());
      // keep offering words while the sink holds off
      if (!quiet && !(k >= PressureAt && k < PressureAt + PressureLen)) idle_sender();
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
